### hdl/uart_rx_ring_pair_assembler_defines.svh
// Assertion macros for the receive ring and byte pair block.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef UART_RX_RING_PAIR_ASSEMBLER_DEFINES_SVH
`define UART_RX_RING_PAIR_ASSEMBLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("urpa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define URPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("urpa assertion failed");

`endif

### hdl/urpa_pkg.sv
// Shared types and constants for the receive ring and byte pair block.
// No dependencies; used by the controller, the datapath and the top level.
package urpa_pkg;

    localparam int RING_SLOTS = 64;
    localparam int IDX_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

    localparam logic FUNC_RX_BYTE  = 1'b0;
    localparam logic FUNC_READ_PAIR = 1'b1;
    localparam logic PORT_MANAGER     = 1'b0;
    localparam logic PORT_SUBORDINATE = 1'b1;

    typedef struct packed {
        logic       func;
        logic       source_port;
        logic [7:0] rx_byte;
        logic       line_error;
    } in_item_t;

    typedef struct packed {
        logic        pair_valid;
        logic [7:0]  pair_first;
        logic [7:0]  pair_second;
        logic        byte_dropped;
        logic [7:0]  last_good_byte;
        logic [31:0] error_total;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAKE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic rx;        // apply a receive event from the input item
        logic rd_start;  // clear the result staging for a read request
        logic pop;       // read the ring at the read index and advance it
        logic take;      // fold the popped byte into the pair logic
        logic load_out;  // move the staged result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic ring_empty;
        logic awaiting;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/uart_rx_ring_pair_assembler.sv
// Receive ring and byte pair assembler, top level.
// Depends on urpa_pkg, urpa_ctrl, urpa_datapath and the defines header.
//
// Input channel (s_valid, s_ready, s_item) takes either a received-byte event
// or a read-pair request. Every accepted item yields exactly one result item
// on the output channel (m_valid, m_ready, m_item), in order.
// Good subordinate-port bytes go into a ring of urpa_pkg::RING_SLOTS bytes
// that keeps one slot free; a byte arriving at a full ring is dropped and
// flagged. A read-pair request pops up to two bytes and reports a pair once
// two have been assembled, holding a lone first byte across requests.
// Steps: a receive event, or a read on an empty ring, goes straight to the
// done step, which loads the output register; a read pops a byte on acceptance
// and folds each popped byte in the take step, popping one more after a first
// byte if the ring holds one, before the done step. One item is in work at a
// time, and the ring has a single registered read port.
// The output register lets the block accept the next item while a result
// waits; that item then holds in its final step until the result is taken.
// Reset (aresetn low, synchronous) empties the ring, clears the pending
// byte, the error count and the last good byte; no clearing pass is needed.
`include "uart_rx_ring_pair_assembler_defines.svh"

module uart_rx_ring_pair_assembler (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  urpa_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output urpa_pkg::out_item_t  m_item
);

    urpa_pkg::ctrl_cmd_t  cmd;
    urpa_pkg::dp_status_t status;

    urpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .item_func (s_item.func),
        .status    (status),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    urpa_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // The ring is never read while it is empty.
    `URPA_ASSERT_SAME(a_no_pop_empty, cmd.pop, !status.ring_empty)
    // A new result never overwrites one that is still waiting.
    `URPA_ASSERT_SAME(a_no_overwrite, cmd.load_out, !m_valid || m_ready)
    // Only one item is in work at a time.
    `URPA_ASSERT_NEXT(a_one_in_work, s_valid && s_ready, !s_ready)

endmodule

### hdl/urpa_ctrl.sv
// Sequencing state machine for the receive ring and byte pair block.
// Depends on urpa_pkg for the state, command and status types.
module urpa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  item_func,
    input  urpa_pkg::dp_status_t  status,
    output logic                  s_ready,
    output urpa_pkg::ctrl_cmd_t   cmd
);

    urpa_pkg::state_t state_reg;
    urpa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= urpa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            urpa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (item_func == urpa_pkg::FUNC_RX_BYTE) begin
                        cmd.rx     = 1'b1;
                        state_next = urpa_pkg::ST_DONE;
                    end else begin
                        cmd.rd_start = 1'b1;
                        if (!status.ring_empty) begin
                            cmd.pop    = 1'b1;
                            state_next = urpa_pkg::ST_TAKE;
                        end else begin
                            state_next = urpa_pkg::ST_DONE;
                        end
                    end
                end
            end
            urpa_pkg::ST_TAKE: begin
                cmd.take = 1'b1;
                // A byte that completes a pair ends the request; a first byte
                // pulls one more from the ring if there is one.
                if (!status.awaiting && !status.ring_empty) begin
                    cmd.pop    = 1'b1;
                    state_next = urpa_pkg::ST_TAKE;
                end else begin
                    state_next = urpa_pkg::ST_DONE;
                end
            end
            urpa_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = urpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = urpa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/urpa_datapath.sv
// Ring memory, indexes, pair assembly, counters and output register.
// Depends on urpa_pkg; driven by commands from urpa_ctrl.
module urpa_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  urpa_pkg::in_item_t    s_item,
    input  urpa_pkg::ctrl_cmd_t   cmd,
    output urpa_pkg::dp_status_t  status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output urpa_pkg::out_item_t   m_item
);

    localparam logic [urpa_pkg::IDX_W-1:0] LAST_IDX =
        urpa_pkg::IDX_W'(urpa_pkg::RING_SLOTS - 1);

    function automatic logic [urpa_pkg::IDX_W-1:0] ring_next(
        input logic [urpa_pkg::IDX_W-1:0] idx
    );
        logic [urpa_pkg::IDX_W-1:0] res;
        if (idx == LAST_IDX) begin
            res = '0;
        end else begin
            res = idx + urpa_pkg::IDX_W'(1);
        end
        return res;
    endfunction

    logic [7:0] ring_mem [urpa_pkg::RING_SLOTS];
    logic [7:0] rd_data_reg;

    logic [urpa_pkg::IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [urpa_pkg::IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]  held_reg, held_next;
    logic        await_reg, await_next;
    logic [31:0] err_cnt_reg, err_cnt_next;
    logic [7:0]  last_good_reg, last_good_next;
    logic        m_valid_reg, m_valid_next;

    logic        stg_valid_reg, stg_valid_next;
    logic [7:0]  stg_first_reg, stg_first_next;
    logic [7:0]  stg_second_reg, stg_second_next;
    logic        stg_dropped_reg, stg_dropped_next;
    urpa_pkg::out_item_t out_reg, out_next;

    logic mem_we;
    logic ring_full;

    assign ring_full = (ring_next(wr_idx_reg) == rd_idx_reg);

    always_comb begin
        wr_idx_next      = wr_idx_reg;
        rd_idx_next      = rd_idx_reg;
        held_next        = held_reg;
        await_next       = await_reg;
        err_cnt_next     = err_cnt_reg;
        last_good_next   = last_good_reg;
        stg_valid_next   = stg_valid_reg;
        stg_first_next   = stg_first_reg;
        stg_second_next  = stg_second_reg;
        stg_dropped_next = stg_dropped_reg;
        mem_we           = 1'b0;

        if (cmd.rx) begin
            stg_valid_next   = 1'b0;
            stg_first_next   = '0;
            stg_second_next  = '0;
            stg_dropped_next = 1'b0;
            if (s_item.line_error) begin
                err_cnt_next = err_cnt_reg + 32'd1;
            end else begin
                last_good_next = s_item.rx_byte;
                if (s_item.source_port == urpa_pkg::PORT_SUBORDINATE) begin
                    if (ring_full) begin
                        stg_dropped_next = 1'b1;
                    end else begin
                        mem_we      = 1'b1;
                        wr_idx_next = ring_next(wr_idx_reg);
                    end
                end
            end
        end

        if (cmd.rd_start) begin
            stg_valid_next   = 1'b0;
            stg_first_next   = '0;
            stg_second_next  = '0;
            stg_dropped_next = 1'b0;
        end

        if (cmd.pop) begin
            rd_idx_next = ring_next(rd_idx_reg);
        end

        if (cmd.take) begin
            if (await_reg) begin
                stg_valid_next  = 1'b1;
                stg_first_next  = held_reg;
                stg_second_next = rd_data_reg;
                await_next      = 1'b0;
            end else begin
                held_next  = rd_data_reg;
                await_next = 1'b1;
            end
        end
    end

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next            = 1'b1;
            out_next.pair_valid     = stg_valid_reg;
            out_next.pair_first     = stg_first_reg;
            out_next.pair_second    = stg_second_reg;
            out_next.byte_dropped   = stg_dropped_reg;
            out_next.last_good_byte = last_good_reg;
            out_next.error_total    = err_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            held_reg      <= '0;
            await_reg     <= 1'b0;
            err_cnt_reg   <= '0;
            last_good_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            held_reg      <= held_next;
            await_reg     <= await_next;
            err_cnt_reg   <= err_cnt_next;
            last_good_reg <= last_good_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stg_valid_reg   <= stg_valid_next;
        stg_first_reg   <= stg_first_next;
        stg_second_reg  <= stg_second_next;
        stg_dropped_reg <= stg_dropped_next;
        out_reg         <= out_next;
    end

    // Single write port and single registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_idx_reg] <= s_item.rx_byte;
        end
        if (cmd.pop) begin
            rd_data_reg <= ring_mem[rd_idx_reg];
        end
    end

    assign status.ring_empty = (rd_idx_reg == wr_idx_reg);
    assign status.awaiting   = await_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule
